// ===== src/qass_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the quote-aware substring search.
// Used by qass_regs, qass_cell and quote_aware_substring_search.
package qass_pkg;

	localparam int unsigned LEN_W   = 4;
	localparam int unsigned PAT_W   = 64;
	localparam int unsigned OFS_W   = 16;
	localparam int unsigned MATCH_W = 16;
	localparam int unsigned ADDR_W  = 6;
	localparam int unsigned DATA_W  = 64;
	localparam int unsigned IDX_W   = 3;

	localparam logic [7:0] QUOTE_SINGLE = 8'h27;
	localparam logic [7:0] QUOTE_DOUBLE = 8'h22;

	localparam logic [IDX_W-1:0] REG_PATTERN_BYTES  = 3'd0;
	localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH = 3'd1;
	localparam logic [IDX_W-1:0] REG_START_OFFSET   = 3'd2;
	localparam logic [IDX_W-1:0] REG_SEARCH_LIMIT   = 3'd3;
	localparam logic [IDX_W-1:0] REG_QUOTE_AWARE    = 3'd4;

	typedef struct packed {
		logic [PAT_W-1:0] pattern_bytes;
		logic [LEN_W-1:0] pattern_length;
		logic [OFS_W-1:0] start_offset;
		logic [OFS_W-1:0] search_limit;
		logic             quote_aware;
	} qass_cfg_t;

	// Broadcast to every compare cell in the chain
	typedef struct packed {
		logic             advance;
		logic             clear;
		logic             active;
		logic [LEN_W-1:0] len;
		logic [7:0]       text;
	} qass_cell_ctl_t;

endpackage

// ===== src/qass_regs.sv =====
`timescale 1ns / 1ps
// APB-style configuration registers of the substring search.
// Depends on qass_pkg for the register map and the config struct.
module qass_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [qass_pkg::ADDR_W-1:0]   paddr,
	input  logic [qass_pkg::DATA_W-1:0]   pwdata,
	output logic [qass_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output qass_pkg::qass_cfg_t           cfg
);

	qass_pkg::qass_cfg_t          cfg_q;
	logic [qass_pkg::IDX_W-1:0]   idx;
	logic                         wr;

	assign pready = 1'b1;
	assign idx    = paddr[qass_pkg::ADDR_W-1:3];
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_bytes  <= '0;
			cfg_q.pattern_length <= '0;
			cfg_q.start_offset   <= '0;
			cfg_q.search_limit   <= '1;
			cfg_q.quote_aware    <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				qass_pkg::REG_PATTERN_BYTES:  cfg_q.pattern_bytes  <= pwdata;
				qass_pkg::REG_PATTERN_LENGTH: cfg_q.pattern_length <= pwdata[qass_pkg::LEN_W-1:0];
				qass_pkg::REG_START_OFFSET:   cfg_q.start_offset   <= pwdata[qass_pkg::OFS_W-1:0];
				qass_pkg::REG_SEARCH_LIMIT:   cfg_q.search_limit   <= pwdata[qass_pkg::OFS_W-1:0];
				qass_pkg::REG_QUOTE_AWARE:    cfg_q.quote_aware    <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			qass_pkg::REG_PATTERN_BYTES:  prdata = cfg_q.pattern_bytes;
			qass_pkg::REG_PATTERN_LENGTH: prdata = qass_pkg::DATA_W'(cfg_q.pattern_length);
			qass_pkg::REG_START_OFFSET:   prdata = qass_pkg::DATA_W'(cfg_q.start_offset);
			qass_pkg::REG_SEARCH_LIMIT:   prdata = qass_pkg::DATA_W'(cfg_q.search_limit);
			qass_pkg::REG_QUOTE_AWARE:    prdata = qass_pkg::DATA_W'(cfg_q.quote_aware);
			default:                      prdata = '0;
		endcase
	end

endmodule

// ===== src/qass_cell.sv =====
`timescale 1ns / 1ps
// One compare cell: holds one partial-match bit for pattern byte IDX.
// Depends on qass_pkg for the control struct; chained by the top level.
module qass_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  qass_pkg::qass_cell_ctl_t ctl,
	input  logic [7:0]              pat_byte,
	input  logic                    chain_in,
	output logic                    chain_out,
	output logic                    hit
);

	logic partial_q;
	logic in_use;
	logic nxt;

	assign in_use    = (qass_pkg::LEN_W+1)'(ctl.len) > (qass_pkg::LEN_W+1)'(IDX);
	assign nxt       = ctl.active && in_use && (pat_byte == ctl.text) && chain_in;
	// Last used cell completes the match
	assign hit       = nxt && (ctl.len == qass_pkg::LEN_W'(IDX + 1));
	assign chain_out = partial_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= 1'b0;
		end else if (ctl.clear) begin
			partial_q <= 1'b0;
		end else if (ctl.advance) begin
			partial_q <= nxt;
		end
	end

endmodule

// ===== src/quote_aware_substring_search.sv =====
`timescale 1ns / 1ps
// Quote-aware fixed-pattern substring search, one text byte per request.
// A result appears on out_valid in the cycle after the request that causes it.
// Throughput: one byte per cycle while the input is not stalled; all compare cells update in the same cycle.
// Input stalls only while a result is held and the output is stalled.
// Reset clears text state and out_valid; registers return to zero, search_limit to all ones.
module quote_aware_substring_search #(
	parameter int unsigned MAX_PATTERN   = 8,
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [qass_pkg::ADDR_W-1:0]   paddr,
	input  logic [qass_pkg::DATA_W-1:0]   pwdata,
	output logic [qass_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    text_byte,
	input  logic                          end_of_text,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found,
	output logic [qass_pkg::MATCH_W-1:0]  match_position
);

	localparam int unsigned EXT_W = 32;
	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	qass_pkg::qass_cfg_t      cfg;
	qass_pkg::qass_cell_ctl_t ctl;

	logic [POSITION_BITS-1:0] pos_q;
	logic                     sq_q;
	logic                     dq_q;
	logic                     answer_given_q;
	logic                     text_ended_q;
	logic                     out_valid_q;
	logic                     found_q;
	logic [qass_pkg::MATCH_W-1:0] match_position_q;

	logic                     acc;
	logic                     live;
	logic                     zero_byte;
	logic                     advance;
	logic                     tog_s;
	logic                     tog_d;
	logic                     may_start;
	logic                     len_ok;
	logic                     hit;
	logic                     ended_now;
	logic                     emit;
	logic [POSITION_BITS-1:0] start_pos;
	logic [EXT_W-1:0]         start_ext;
	logic [MAX_PATTERN:0]     chain;
	logic [MAX_PATTERN-1:0]   hits;

	qass_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_stall  = out_valid_q && out_stall;
	assign acc       = in_valid && !in_stall;
	assign live      = !text_ended_q && !answer_given_q;
	assign zero_byte = (text_byte == 8'd0);
	assign advance   = acc && live && !zero_byte;

	assign tog_s = (text_byte == qass_pkg::QUOTE_SINGLE) && !dq_q;
	assign tog_d = (text_byte == qass_pkg::QUOTE_DOUBLE) && !sq_q;

	assign may_start = (!cfg.quote_aware || (!sq_q && !dq_q && !tog_s && !tog_d))
		&& (EXT_W'(pos_q) >= EXT_W'(cfg.start_offset))
		&& (EXT_W'(pos_q) <  EXT_W'(cfg.search_limit));

	assign len_ok = (cfg.pattern_length != '0)
		&& (EXT_W'(cfg.pattern_length) <= EXT_W'(MAX_PATTERN));

	assign ctl.advance = advance;
	assign ctl.clear   = acc && end_of_text;
	assign ctl.active  = len_ok && (pos_q != POS_MAX);
	assign ctl.len     = cfg.pattern_length;
	assign ctl.text    = text_byte;

	assign chain[0] = may_start;

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		qass_cell #(.IDX(k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.pat_byte  (cfg.pattern_bytes[8*k +: 8]),
			.chain_in  (chain[k]),
			.chain_out (chain[k+1]),
			.hit       (hits[k])
		);
	end

	assign hit       = advance && (|hits);
	assign start_pos = pos_q - POSITION_BITS'(cfg.pattern_length - qass_pkg::LEN_W'(1));
	assign start_ext = EXT_W'(start_pos);
	assign ended_now = text_ended_q || (live && zero_byte);
	assign emit      = acc && !answer_given_q && (hit || ended_now || end_of_text);

	// Per-text state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			sq_q           <= 1'b0;
			dq_q           <= 1'b0;
			answer_given_q <= 1'b0;
			text_ended_q   <= 1'b0;
		end else if (acc) begin
			if (end_of_text) begin
				pos_q          <= '0;
				sq_q           <= 1'b0;
				dq_q           <= 1'b0;
				answer_given_q <= 1'b0;
				text_ended_q   <= 1'b0;
			end else begin
				if (advance) begin
					if (tog_s) begin
						sq_q <= !sq_q;
					end else if (tog_d) begin
						dq_q <= !dq_q;
					end
					if (pos_q != POS_MAX) begin
						pos_q <= pos_q + POSITION_BITS'(1);
					end
				end
				text_ended_q   <= ended_now;
				answer_given_q <= answer_given_q || emit;
			end
		end
	end

	// Output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found_q          <= hit;
			match_position_q <= hit ? start_ext[qass_pkg::MATCH_W-1:0] : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign match_position = match_position_q;

	a_one_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && answer_given_q) |-> !emit)
		else $error("result after answer already given");

	a_answer_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !end_of_text) |=> answer_given_q)
		else $error("answer flag not set after result");

	a_start_window: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> (EXT_W'(start_pos) >= EXT_W'(cfg.start_offset)
			&& EXT_W'(start_pos) < EXT_W'(cfg.search_limit)))
		else $error("match start outside allowed window");

	a_pos_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !end_of_text) |=> (pos_q >= $past(pos_q)))
		else $error("text position moved backward within a text");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for quote_aware_substring_search: streams texts, predicts each answer
// and compares every result in order. Depends on qass_pkg and the search top level only.
module testbench;

	localparam int unsigned MAX_PAT     = 8;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned HOLD_CYCLES = 300;

	typedef struct packed {
		logic        found;
		logic [15:0] pos;
	} search_answer_t;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [qass_pkg::ADDR_W-1:0] paddr;
	logic [qass_pkg::DATA_W-1:0] pwdata;
	logic [qass_pkg::DATA_W-1:0] prdata;
	logic                        pready;
	logic                        in_valid;
	logic                        in_stall;
	logic [7:0]                  text_byte;
	logic                        end_of_text;
	logic                        out_valid;
	logic                        out_stall;
	logic                        found;
	logic [15:0]                 match_position;

	quote_aware_substring_search i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.text_byte      (text_byte),
		.end_of_text    (end_of_text),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found          (found),
		.match_position (match_position)
	);

	// Register shadow
	logic [63:0] cfg_pattern;
	logic [3:0]  cfg_len;
	logic [15:0] cfg_from;
	logic [15:0] cfg_limit;
	logic        cfg_quotes;

	// Per-text search state
	logic [7:0]  partial;
	logic        in_squote;
	logic        in_dquote;
	logic [15:0] text_pos;
	logic        answered;
	logic        text_done;

	search_answer_t pending_answers[$];
	search_answer_t oldest;

	int unsigned in_idle_pct;
	int unsigned rcv_stall_pct;
	bit          hold_req;
	int unsigned hold_left;
	int unsigned cycle_count;
	int unsigned n_errors;
	int unsigned n_scanned;
	int unsigned n_sent;
	int unsigned n_answers;
	int unsigned n_matches;
	int unsigned n_writes;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
		end
	end

	task automatic note_failure(input string what, input search_answer_t want,
			input logic got_found, input logic [15:0] got_pos);
		n_errors++;
		if (n_errors <= 10)
			$display("tb: %s: expected found=%0b pos=%0d, got found=%0b pos=%0d",
				what, want.found, want.pos, got_found, got_pos);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_answers++;
			if (found)
				n_matches++;
			if (pending_answers.size() == 0) begin
				note_failure("unexpected result", '0, found, match_position);
			end else begin
				oldest = pending_answers.pop_front();
				if (found !== oldest.found || match_position !== oldest.pos)
					note_failure("mismatch", oldest, found, match_position);
			end
		end
	end

	function automatic void clear_text();
		partial   = '0;
		in_squote = 1'b0;
		in_dquote = 1'b0;
		text_pos  = '0;
		answered  = 1'b0;
		text_done = 1'b0;
	endfunction

	// Advance quote state and partial matches by one byte; return 1 on a completed match
	function automatic bit scan_byte(input logic [7:0] c, output logic [15:0] start);
		logic       unquoted;
		logic       toggles;
		logic       may_start;
		logic [7:0] chain;
		logic [7:0] next;
		bit         hit;
		unquoted = !in_squote && !in_dquote;
		toggles  = 1'b0;
		next     = '0;
		hit      = 1'b0;
		start    = '0;
		if (c == qass_pkg::QUOTE_SINGLE && !in_dquote) begin
			in_squote = !in_squote;
			toggles   = 1'b1;
		end else if (c == qass_pkg::QUOTE_DOUBLE && !in_squote) begin
			in_dquote = !in_dquote;
			toggles   = 1'b1;
		end
		may_start = (!cfg_quotes || (unquoted && !toggles))
			&& text_pos >= cfg_from && text_pos < cfg_limit;
		if (cfg_len >= 1 && cfg_len <= MAX_PAT && text_pos != 16'hFFFF) begin
			chain = {partial[6:0], may_start};
			for (int k = 0; k < MAX_PAT; k++)
				if (k < cfg_len && cfg_pattern[8*k +: 8] == c && chain[k])
					next[k] = 1'b1;
			if (next[cfg_len - 1]) begin
				hit   = 1'b1;
				start = text_pos - (16'(cfg_len) - 16'd1);
			end
		end
		partial = next;
		if (text_pos != 16'hFFFF)
			text_pos++;
		return hit;
	endfunction

	function automatic void search_step(input logic [7:0] c, input logic eot);
		logic [15:0] start;
		if (!text_done && !answered) begin
			n_scanned++;
			if (c == 8'h00) begin
				text_done = 1'b1;
			end else if (scan_byte(c, start)) begin
				pending_answers.push_back('{found: 1'b1, pos: start});
				answered = 1'b1;
			end
		end
		if (!answered && (text_done || eot)) begin
			pending_answers.push_back('{found: 1'b0, pos: 16'd0});
			answered = 1'b1;
		end
		if (eot)
			clear_text();
	endfunction

	task automatic send_char(input logic [7:0] c, input logic eot);
		@(negedge clk);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		text_byte   <= c;
		end_of_text <= eot;
		do @(posedge clk); while (in_stall);
		n_sent++;
		search_step(c, eot);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	// Drop the request and let every expected answer drain
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [qass_pkg::IDX_W-1:0] idx, input logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			qass_pkg::REG_PATTERN_BYTES:  cfg_pattern = value;
			qass_pkg::REG_PATTERN_LENGTH: cfg_len     = value[3:0];
			qass_pkg::REG_START_OFFSET:   cfg_from    = value[15:0];
			qass_pkg::REG_SEARCH_LIMIT:   cfg_limit   = value[15:0];
			qass_pkg::REG_QUOTE_AWARE:    cfg_quotes  = value[0];
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apply_config(input logic [63:0] pattern, input logic [3:0] len,
			input logic [15:0] from, input logic [15:0] limit, input logic quotes);
		wait_idle();
		cfg_write(qass_pkg::REG_PATTERN_BYTES, pattern);
		cfg_write(qass_pkg::REG_PATTERN_LENGTH, 64'(len));
		cfg_write(qass_pkg::REG_START_OFFSET, 64'(from));
		cfg_write(qass_pkg::REG_SEARCH_LIMIT, 64'(limit));
		cfg_write(qass_pkg::REG_QUOTE_AWARE, 64'(quotes));
	endtask

	function automatic logic [7:0] pick_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 8'h00;
		if (r < 13)
			return 8'($urandom_range(1, 255));
		case ($urandom_range(0, 4))
			0: return "a";
			1: return "b";
			2: return qass_pkg::QUOTE_SINGLE;
			3: return qass_pkg::QUOTE_DOUBLE;
			default: return "x";
		endcase
	endfunction

	task automatic random_config();
		logic [63:0] pattern;
		logic [3:0]  len;
		logic [15:0] from;
		logic [15:0] limit;
		int unsigned r;
		for (int k = 0; k < 8; k++)
			pattern[8*k +: 8] = pick_char();
		if ($urandom_range(0, 9) == 0)
			pattern = {$urandom, $urandom};
		r = $urandom_range(0, 99);
		if (r < 5)
			len = 4'd0;
		else if (r < 10)
			len = 4'($urandom_range(9, 15));
		else if (r < 15)
			len = 4'd8;
		else
			len = 4'($urandom_range(1, 4));
		r = $urandom_range(0, 99);
		if (r < 70)
			from = 16'd0;
		else if (r < 90)
			from = 16'($urandom_range(0, 6));
		else if (r < 95)
			from = 16'hFFFF;
		else
			from = 16'($urandom);
		r = $urandom_range(0, 99);
		if (r < 70)
			limit = 16'hFFFF;
		else if (r < 90)
			limit = 16'($urandom_range(0, 12));
		else if (r < 95)
			limit = 16'd0;
		else
			limit = 16'($urandom);
		apply_config(pattern, len, from, limit, 1'($urandom));
	endtask

	// Random text, usually with the pattern (or a cut-off prefix of it) planted inside
	task automatic send_random_text();
		logic [7:0]  txt[$];
		int unsigned n;
		int unsigned at;
		n = $urandom_range(1, 16);
		for (int i = 0; i < n; i++)
			txt.push_back(pick_char());
		if (cfg_len >= 1 && cfg_len <= MAX_PAT && $urandom_range(0, 99) < 60) begin
			at = $urandom_range(0, n - 1);
			for (int k = 0; k < cfg_len; k++)
				if (at + k < n)
					txt[at + k] = cfg_pattern[8*k +: 8];
		end
		for (int i = 0; i < n; i++)
			send_char(txt[i], i == n - 1);
	endtask

	task automatic test_defaults();
		send_text("ab");
	endtask

	task automatic test_plain_match();
		apply_config(64'h6261, 4'd2, 16'd0, 16'hFFFF, 1'b0);
		send_text("xab");
	endtask

	task automatic test_zero_byte();
		send_char("x", 1'b0);
		send_char(8'h00, 1'b0);
		send_char("q", 1'b1);
	endtask

	task automatic test_quote_rules();
		apply_config(64'h6261, 4'd2, 16'd0, 16'hFFFF, 1'b1);
		// single quote inside double quotes must not toggle
		send_text("\"'\"ab");
		apply_config({56'h0, "a", qass_pkg::QUOTE_SINGLE}, 4'd2, 16'd0, 16'hFFFF, 1'b1);
		send_text("'a");
	endtask

	task automatic test_search_window();
		apply_config(64'h61, 4'd1, 16'd2, 16'd3, 1'b0);
		send_text("aaa");
		apply_config(64'h61, 4'd1, 16'hFFFF, 16'd0, 1'b0);
		send_text("a");
	endtask

	task automatic test_pattern_extremes();
		apply_config('1, 4'd8, 16'd0, 16'hFFFF, 1'b0);
		for (int i = 0; i < 8; i++)
			send_char(8'hFF, i == 7);
		apply_config('1, 4'd15, 16'd0, 16'hFFFF, 1'b0);
		send_char(8'hFF, 1'b1);
	endtask

	task automatic test_random_texts(input int unsigned items);
		int unsigned first;
		first = n_sent;
		while (n_sent - first < items) begin
			if ($urandom_range(0, 99) < 25)
				random_config();
			send_random_text();
		end
	endtask

	// Hold the output off while requests keep coming, so the block fills and stalls its input
	task automatic test_output_hold();
		apply_config(64'h61, 4'd1, 16'd0, 16'hFFFF, 1'b0);
		hold_req = 1'b1;
		for (int i = 0; i < 8; i++)
			send_text("ab");
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		text_byte     = '0;
		end_of_text   = 1'b0;
		out_stall     = 1'b0;
		in_idle_pct   = 29;
		rcv_stall_pct = 68;
		hold_req      = 1'b0;
		hold_left     = 0;
		cycle_count   = 0;
		n_errors      = 0;
		n_scanned     = 0;
		n_sent        = 0;
		n_answers     = 0;
		n_matches     = 0;
		n_writes      = 0;
		cfg_pattern   = '0;
		cfg_len       = '0;
		cfg_from      = '0;
		cfg_limit     = 16'hFFFF;
		cfg_quotes    = 1'b0;
		clear_text();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_defaults();
		test_plain_match();
		test_zero_byte();
		test_quote_rules();
		test_search_window();
		test_pattern_extremes();
		test_random_texts(430);
		in_idle_pct   = 68;
		rcv_stall_pct = 29;
		test_random_texts(430);
		in_idle_pct   = 0;
		rcv_stall_pct = 0;
		test_output_hold();
		test_random_texts(430);

		wait_idle();
		repeat (5) @(posedge clk);
		n_errors += pending_answers.size();
		$display("tb: %0d bytes sent, %0d scanned, %0d answers checked (%0d matches), %0d writes",
			n_sent, n_scanned, n_answers, n_matches, n_writes);
		$display("tb: covered quotes, zero bytes, search windows, pattern extremes and a long hold");
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
src/qass_pkg.sv
src/qass_regs.sv
src/qass_cell.sv
src/quote_aware_substring_search.sv
bench/testbench.sv
